// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the back-projection core.
// Both sample on the rising edge of clock; the first one is quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DPBP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`define DPBP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/dpbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dpbp_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int POS_BITS_DEF   = 20;

   localparam int DEPTH_BITS     = 16;
   localparam int CENTER_BITS    = 16;
   localparam int CENTER_FRAC    = 4;
   localparam int INV_BITS       = 32;
   localparam int INV_HALF       = 16;
   localparam int FRAC_BITS      = CENTER_FRAC + INV_BITS;
   localparam int BOX_BITS       = 20;
   localparam int BOX_PACK_BITS  = 3 * BOX_BITS;
   localparam int COLOR_BITS     = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = BOX_PACK_BITS;

   // Five stages of projection arithmetic, then the output register.
   localparam int PROJ_STAGES    = 5;
   localparam int NUM_STAGES     = PROJ_STAGES + 1;

   localparam logic [CENTER_BITS-1:0]   CENTER_X_RESET = 16'd5120;
   localparam logic [CENTER_BITS-1:0]   CENTER_Y_RESET = 16'd3840;
   localparam logic [INV_BITS-1:0]      INV_FOCAL_RESET = 32'd8180905;
   localparam logic [BOX_PACK_BITS-1:0] BOX_RESET = '0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X  = 3'd0,
      CSR_CENTER_Y  = 3'd1,
      CSR_INV_FOC_X = 3'd2,
      CSR_INV_FOC_Y = 3'd3,
      CSR_BOX_LOWER = 3'd4,
      CSR_BOX_UPPER = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth;
      logic                  mask;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } side_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dpbp_pipe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dpbp_pipe_ctrl
   import dpbp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    rsp_stall,
   output logic         req_stall,
   output pipe_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // A stage takes new data when it is empty or its contents move on, so bubbles close up.
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (load[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall  = !load[0];
   assign ctrl.load  = load;
   assign ctrl.valid = valid_ff;

   `DPBP_ASSERT(a_stall_only_when_full, req_stall |-> valid_ff[0], "input stalled with stage empty")
   `DPBP_ASSERT(a_held_stage_keeps_item, !$past(reset) |-> ((valid_ff & $past(valid_ff & ~load)) == $past(valid_ff & ~load)), "held stage lost its item")
   `DPBP_ASSERT_ALWAYS(a_reset_empties, $past(reset) |-> (valid_ff == '0), "pipeline not empty after reset")

endmodule

`default_nettype wire

// ----- rtl/core/dpbp_project.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dpbp_project
   import dpbp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int POS_BITS   = POS_BITS_DEF
)
(
   input  wire logic                   clock,
   input  wire pipe_ctrl_type          ctrl,
   input  wire logic [COORD_BITS-1:0]  pix,
   input  wire logic [CENTER_BITS-1:0] centre,
   input  wire logic [INV_BITS-1:0]    inv,
   input  wire logic [DEPTH_BITS-1:0]  depth,
   output logic signed [POS_BITS-1:0]  pos
);

   localparam int P16_W = COORD_BITS + CENTER_FRAC;
   localparam int MAG_W = max_int(P16_W, CENTER_BITS);
   localparam int PROD_W = MAG_W + DEPTH_BITS;
   localparam int PP_W = PROD_W + INV_HALF;
   localparam int SUM_W = PROD_W + INV_BITS + 1;
   localparam int Q_W = SUM_W - FRAC_BITS;
   localparam int SAT_W = max_int(Q_W, POS_BITS) + 1;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic [SAT_W-1:0] LIM_NEG = SAT_W'(1) << (POS_BITS - 1);
   localparam logic [SAT_W-1:0] LIM_POS = LIM_NEG - SAT_W'(1);

   // Stage 0: signed offset from the principal point, kept as sign and magnitude.
   logic [P16_W-1:0]      p16;
   logic [MAG_W-1:0]      p16_ext;
   logic [MAG_W-1:0]      centre_ext;
   logic                  neg_in;
   logic [MAG_W-1:0]      mag_in;
   logic [MAG_W-1:0]      mag_ff;
   logic                  neg0_ff;
   logic [DEPTH_BITS-1:0] depth_ff;

   assign p16        = {pix, {CENTER_FRAC{1'b0}}};
   assign p16_ext    = MAG_W'(p16);
   assign centre_ext = MAG_W'(centre);
   assign neg_in     = centre_ext > p16_ext;
   assign mag_in     = neg_in ? (centre_ext - p16_ext) : (p16_ext - centre_ext);

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         mag_ff   <= mag_in;
         neg0_ff  <= neg_in;
         depth_ff <= depth;
      end
   end

   // Stage 1: offset times depth.
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;
   logic              neg1_ff;

   assign prod_in = PROD_W'(mag_ff) * PROD_W'(depth_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         prod_ff <= prod_in;
         neg1_ff <= neg0_ff;
      end
   end

   // Stage 2: the reciprocal is split into halves to keep each multiplier narrow.
   logic [PP_W-1:0] pp_hi_in;
   logic [PP_W-1:0] pp_lo_in;
   logic [PP_W-1:0] pp_hi_ff;
   logic [PP_W-1:0] pp_lo_ff;
   logic            neg2_ff;

   assign pp_hi_in = PP_W'(prod_ff) * PP_W'(inv[INV_BITS-1:INV_HALF]);
   assign pp_lo_in = PP_W'(prod_ff) * PP_W'(inv[INV_HALF-1:0]);

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         pp_hi_ff <= pp_hi_in;
         pp_lo_ff <= pp_lo_in;
         neg2_ff  <= neg1_ff;
      end
   end

   // Stage 3: recombine and round the magnitude, halves going up.
   logic [SUM_W-1:0] sum_in;
   logic [Q_W-1:0]   q_in;
   logic [Q_W-1:0]   q_ff;
   logic             neg3_ff;

   assign sum_in = (SUM_W'(pp_hi_ff) << INV_HALF) + SUM_W'(pp_lo_ff) + ROUND_HALF;
   assign q_in   = sum_in[SUM_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         q_ff    <= q_in;
         neg3_ff <= neg2_ff;
      end
   end

   // Stage 4: saturate to the output range and apply the sign.
   logic [SAT_W-1:0]           q_ext;
   logic [SAT_W-1:0]           mag_sat;
   logic signed [POS_BITS-1:0] pos_in;
   logic signed [POS_BITS-1:0] pos_ff;

   always_comb begin
      q_ext = SAT_W'(q_ff);
      if (neg3_ff) begin
         mag_sat = (q_ext > LIM_NEG) ? LIM_NEG : q_ext;
         pos_in  = POS_BITS'(SAT_W'(0) - mag_sat);
      end else begin
         mag_sat = (q_ext > LIM_POS) ? LIM_POS : q_ext;
         pos_in  = POS_BITS'(mag_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

`default_nettype wire

// ----- rtl/core/dpbp_box_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dpbp_box_check
   import dpbp_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
)
(
   input  wire logic                       clock,
   input  wire pipe_ctrl_type              ctrl,
   input  wire logic signed [POS_BITS-1:0] x,
   input  wire logic signed [POS_BITS-1:0] y,
   input  wire logic [DEPTH_BITS-1:0]      depth,
   input  wire logic                       mask,
   input  wire logic [BOX_PACK_BITS-1:0]   box_lower,
   input  wire logic [BOX_PACK_BITS-1:0]   box_upper,
   output logic                            in_filtered
);

   localparam int CMP_W = max_int(POS_BITS, BOX_BITS) + 1;

   logic signed [CMP_W-1:0] x_ext;
   logic signed [CMP_W-1:0] y_ext;
   logic signed [CMP_W-1:0] z_ext;
   logic signed [CMP_W-1:0] lo_x;
   logic signed [CMP_W-1:0] lo_y;
   logic signed [CMP_W-1:0] lo_z;
   logic signed [CMP_W-1:0] hi_x;
   logic signed [CMP_W-1:0] hi_y;
   logic signed [CMP_W-1:0] hi_z;
   logic                    inside_in;
   logic                    in_filtered_ff;

   assign x_ext = CMP_W'(x);
   assign y_ext = CMP_W'(y);
   assign z_ext = $signed(CMP_W'(depth));
   assign lo_x  = CMP_W'($signed(box_lower[0 +: BOX_BITS]));
   assign lo_y  = CMP_W'($signed(box_lower[BOX_BITS +: BOX_BITS]));
   assign lo_z  = CMP_W'($signed(box_lower[2*BOX_BITS +: BOX_BITS]));
   assign hi_x  = CMP_W'($signed(box_upper[0 +: BOX_BITS]));
   assign hi_y  = CMP_W'($signed(box_upper[BOX_BITS +: BOX_BITS]));
   assign hi_z  = CMP_W'($signed(box_upper[2*BOX_BITS +: BOX_BITS]));

   // Bounds are inclusive; an inverted box therefore keeps nothing.
   assign inside_in = (depth != '0) && mask
                      && (x_ext >= lo_x) && (x_ext <= hi_x)
                      && (y_ext >= lo_y) && (y_ext <= hi_y)
                      && (z_ext >= lo_z) && (z_ext <= hi_z);

   always_ff @(posedge clock) begin
      if (ctrl.load[NUM_STAGES-1]) begin
         in_filtered_ff <= inside_in;
      end
   end

   assign in_filtered = in_filtered_ff;

endmodule

`default_nettype wire

// ----- rtl/core/depth_pixel_backprojection_core.sv -----
// Back-projects one depth pixel per clock, unless stalled, into a millimetre point with colour.
// Six register stages hold a pixel between its input transfer and its valid result.
// Throughput: one pixel per cycle while the result side does not stall, set by the pipelined multiplier chain.
// Stalls on the result side hold each occupied stage with no empty stage after it; empty stages still fill.
// Reset (synchronous, active high) empties the pipeline and loads default registers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module depth_pixel_backprojection_core
   import dpbp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int POS_BITS   = POS_BITS_DEF
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [COORD_BITS-1:0]     req_col,
   input  wire logic [COORD_BITS-1:0]     req_row,
   input  wire logic [DEPTH_BITS-1:0]     req_depth_mm,
   input  wire logic                      req_mask_bit,
   input  wire logic [COLOR_BITS-1:0]     req_red_in,
   input  wire logic [COLOR_BITS-1:0]     req_green_in,
   input  wire logic [COLOR_BITS-1:0]     req_blue_in,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [POS_BITS-1:0]     rsp_pos_x,
   output logic signed [POS_BITS-1:0]     rsp_pos_y,
   output logic [DEPTH_BITS-1:0]          rsp_pos_z,
   output logic [COLOR_BITS-1:0]          rsp_red_out,
   output logic [COLOR_BITS-1:0]          rsp_green_out,
   output logic [COLOR_BITS-1:0]          rsp_blue_out,
   output logic                           rsp_point_valid,
   output logic                           rsp_in_filtered,

   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers.
   logic [CENTER_BITS-1:0]   center_x_ff;
   logic [CENTER_BITS-1:0]   center_x_in;
   logic [CENTER_BITS-1:0]   center_y_ff;
   logic [CENTER_BITS-1:0]   center_y_in;
   logic [INV_BITS-1:0]      inv_focal_x_ff;
   logic [INV_BITS-1:0]      inv_focal_x_in;
   logic [INV_BITS-1:0]      inv_focal_y_ff;
   logic [INV_BITS-1:0]      inv_focal_y_in;
   logic [BOX_PACK_BITS-1:0] box_lower_ff;
   logic [BOX_PACK_BITS-1:0] box_lower_in;
   logic [BOX_PACK_BITS-1:0] box_upper_ff;
   logic [BOX_PACK_BITS-1:0] box_upper_in;

   always_comb begin
      center_x_in    = center_x_ff;
      center_y_in    = center_y_ff;
      inv_focal_x_in = inv_focal_x_ff;
      inv_focal_y_in = inv_focal_y_ff;
      box_lower_in   = box_lower_ff;
      box_upper_in   = box_upper_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CENTER_X:  center_x_in    = csr_wdata[CENTER_BITS-1:0];
            CSR_CENTER_Y:  center_y_in    = csr_wdata[CENTER_BITS-1:0];
            CSR_INV_FOC_X: inv_focal_x_in = csr_wdata[INV_BITS-1:0];
            CSR_INV_FOC_Y: inv_focal_y_in = csr_wdata[INV_BITS-1:0];
            CSR_BOX_LOWER: box_lower_in   = csr_wdata[BOX_PACK_BITS-1:0];
            CSR_BOX_UPPER: box_upper_in   = csr_wdata[BOX_PACK_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= CENTER_X_RESET;
         center_y_ff    <= CENTER_Y_RESET;
         inv_focal_x_ff <= INV_FOCAL_RESET;
         inv_focal_y_ff <= INV_FOCAL_RESET;
         box_lower_ff   <= BOX_RESET;
         box_upper_ff   <= BOX_RESET;
      end else begin
         center_x_ff    <= center_x_in;
         center_y_ff    <= center_y_in;
         inv_focal_x_ff <= inv_focal_x_in;
         inv_focal_y_ff <= inv_focal_y_in;
         box_lower_ff   <= box_lower_in;
         box_upper_ff   <= box_upper_in;
      end
   end

   // Pipeline control.
   pipe_ctrl_type ctrl;

   dpbp_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   // Both axes use the same arithmetic, each in its own instance.
   logic signed [POS_BITS-1:0] proj_x;
   logic signed [POS_BITS-1:0] proj_y;

   dpbp_project #(
      .COORD_BITS (COORD_BITS),
      .POS_BITS   (POS_BITS)
   ) u_proj_x (
      .clock  (clock),
      .ctrl   (ctrl),
      .pix    (req_col),
      .centre (center_x_ff),
      .inv    (inv_focal_x_ff),
      .depth  (req_depth_mm),
      .pos    (proj_x)
   );

   dpbp_project #(
      .COORD_BITS (COORD_BITS),
      .POS_BITS   (POS_BITS)
   ) u_proj_y (
      .clock  (clock),
      .ctrl   (ctrl),
      .pix    (req_row),
      .centre (center_y_ff),
      .inv    (inv_focal_y_ff),
      .depth  (req_depth_mm),
      .pos    (proj_y)
   );

   // Depth, mask and colour ride alongside the arithmetic.
   side_type side_ff [PROJ_STAGES];
   side_type side_in [PROJ_STAGES];

   always_comb begin
      side_in[0].depth = req_depth_mm;
      side_in[0].mask  = req_mask_bit;
      side_in[0].red   = req_red_in;
      side_in[0].green = req_green_in;
      side_in[0].blue  = req_blue_in;
      for (int i = 1; i < PROJ_STAGES; i++) begin
         side_in[i] = side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PROJ_STAGES; i++) begin
         if (ctrl.load[i]) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   dpbp_box_check #(
      .POS_BITS (POS_BITS)
   ) u_box (
      .clock       (clock),
      .ctrl        (ctrl),
      .x           (proj_x),
      .y           (proj_y),
      .depth       (side_ff[PROJ_STAGES-1].depth),
      .mask        (side_ff[PROJ_STAGES-1].mask),
      .box_lower   (box_lower_ff),
      .box_upper   (box_upper_ff),
      .in_filtered (rsp_in_filtered)
   );

   // Output register.
   logic signed [POS_BITS-1:0] pos_x_ff;
   logic signed [POS_BITS-1:0] pos_y_ff;
   logic [DEPTH_BITS-1:0]      pos_z_ff;
   logic [COLOR_BITS-1:0]      red_ff;
   logic [COLOR_BITS-1:0]      green_ff;
   logic [COLOR_BITS-1:0]      blue_ff;
   logic                       point_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[NUM_STAGES-1]) begin
         pos_x_ff       <= proj_x;
         pos_y_ff       <= proj_y;
         pos_z_ff       <= side_ff[PROJ_STAGES-1].depth;
         red_ff         <= side_ff[PROJ_STAGES-1].red;
         green_ff       <= side_ff[PROJ_STAGES-1].green;
         blue_ff        <= side_ff[PROJ_STAGES-1].blue;
         point_valid_ff <= side_ff[PROJ_STAGES-1].depth != '0;
      end
   end

   assign rsp_valid       = ctrl.valid[NUM_STAGES-1];
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_red_out     = red_ff;
   assign rsp_green_out   = green_ff;
   assign rsp_blue_out    = blue_ff;
   assign rsp_point_valid = point_valid_ff;

   `DPBP_ASSERT(a_kept_implies_valid, (rsp_valid && rsp_in_filtered) |-> rsp_point_valid, "kept point without depth")
   `DPBP_ASSERT(a_no_depth_zero_point, (rsp_valid && !rsp_point_valid) |-> ((rsp_pos_x == '0) && (rsp_pos_y == '0) && (rsp_pos_z == '0)), "invalid point has nonzero position")
   `DPBP_ASSERT(a_stalled_result_holds, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_z)), "stalled result changed")

endmodule

`default_nettype wire

// ----- tb/tb_depth_pixel_backprojection_core.sv -----
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection_core;
   import dpbp_pkg::*;

   localparam int COORD_W = COORD_BITS_DEF;
   localparam int POS_W = POS_BITS_DEF;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS = 62;
   localparam int BOX_MIN = -(1 << (BOX_BITS - 1));
   localparam int BOX_MAX = (1 << (BOX_BITS - 1)) - 1;
   localparam int POS_MIN = -(1 << (POS_W - 1));
   localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
   localparam int PIX_MAX = (1 << COORD_W) - 1;
   localparam int DEPTH_MAX = (1 << DEPTH_BITS) - 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 3'd7;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef struct packed {
      logic [COORD_W-1:0]    col;
      logic [COORD_W-1:0]    row;
      logic [DEPTH_BITS-1:0] depth;
      logic                  mask;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [DEPTH_BITS-1:0]   z;
      logic [COLOR_BITS-1:0]   red;
      logic [COLOR_BITS-1:0]   green;
      logic [COLOR_BITS-1:0]   blue;
      logic                    valid;
      logic                    kept;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [COORD_W-1:0]      req_col = '0;
   logic [COORD_W-1:0]      req_row = '0;
   logic [DEPTH_BITS-1:0]   req_depth_mm = '0;
   logic                    req_mask_bit = 1'b0;
   logic [COLOR_BITS-1:0]   req_red_in = '0;
   logic [COLOR_BITS-1:0]   req_green_in = '0;
   logic [COLOR_BITS-1:0]   req_blue_in = '0;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic [DEPTH_BITS-1:0]   rsp_pos_z;
   logic [COLOR_BITS-1:0]   rsp_red_out;
   logic [COLOR_BITS-1:0]   rsp_green_out;
   logic [COLOR_BITS-1:0]   rsp_blue_out;
   logic                    rsp_point_valid;
   logic                    rsp_in_filtered;

   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Testbench copy of the camera and box registers.
   logic [CENTER_BITS-1:0]   cfg_centre_col = CENTER_X_RESET;
   logic [CENTER_BITS-1:0]   cfg_centre_row = CENTER_Y_RESET;
   logic [INV_BITS-1:0]      cfg_recip_fx = INV_FOCAL_RESET;
   logic [INV_BITS-1:0]      cfg_recip_fy = INV_FOCAL_RESET;
   logic [BOX_PACK_BITS-1:0] cfg_box_min = BOX_RESET;
   logic [BOX_PACK_BITS-1:0] cfg_box_max = BOX_RESET;

   pixel_type pending_pixels[$];
   point_type projected_points[$];
   pixel_type shown_pixel;

   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int idle_cycles = 0;
   int error_count = 0;
   int pixels_sent = 0;
   int points_checked = 0;
   int points_kept = 0;
   int points_empty = 0;
   int points_saturated = 0;
   int settings_used = 0;

   depth_pixel_backprojection_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_depth_mm    (req_depth_mm),
      .req_mask_bit    (req_mask_bit),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_point_valid (rsp_point_valid),
      .rsp_in_filtered (rsp_in_filtered),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // Offset from the principal point times depth times the reciprocal focal length,
   // rounded half away from zero on the magnitude and saturated to the output width.
   function automatic logic [POS_W-1:0] project_axis(input logic [COORD_W-1:0] pix,
                                                     input logic [CENTER_BITS-1:0] centre,
                                                     input logic [INV_BITS-1:0] recip,
                                                     input logic [DEPTH_BITS-1:0] depth);
      logic [79:0] pos;
      logic [79:0] ctr;
      logic [79:0] mag;
      logic [79:0] dep;
      logic [79:0] rcp;
      logic [79:0] q;
      logic [79:0] lim;
      logic [POS_W-1:0] r;
      logic neg;
      pos = pix;
      pos = pos << CENTER_FRAC;
      ctr = centre;
      dep = depth;
      rcp = recip;
      neg = ctr > pos;
      mag = neg ? ctr - pos : pos - ctr;
      q = (mag * dep * rcp + (80'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      lim = 80'd1 << (POS_W - 1);
      if (!neg && q >= lim) q = lim - 1;
      if (neg && q > lim) q = lim;
      r = q[POS_W-1:0];
      return neg ? -r : r;
   endfunction

   function automatic logic in_slab(input longint v, input int axis);
      logic signed [BOX_BITS-1:0] lo;
      logic signed [BOX_BITS-1:0] hi;
      lo = cfg_box_min[axis*BOX_BITS +: BOX_BITS];
      hi = cfg_box_max[axis*BOX_BITS +: BOX_BITS];
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic point_type project_pixel(input pixel_type p);
      point_type pt;
      pt = '0;
      pt.red = p.red;
      pt.green = p.green;
      pt.blue = p.blue;
      pt.valid = (p.depth != 0);
      if (pt.valid) begin
         pt.x = project_axis(p.col, cfg_centre_col, cfg_recip_fx, p.depth);
         pt.y = project_axis(p.row, cfg_centre_row, cfg_recip_fy, p.depth);
         pt.z = p.depth;
         pt.kept = p.mask && in_slab($signed(pt.x), 0) && in_slab($signed(pt.y), 1)
                   && in_slab(longint'(pt.z), 2);
      end
      return pt;
   endfunction

   function automatic pixel_type pixel_of(input int col, input int row, input int depth,
                                          input int mask, input int red, input int green,
                                          input int blue);
      pixel_type p;
      p.col = col[COORD_W-1:0];
      p.row = row[COORD_W-1:0];
      p.depth = depth[DEPTH_BITS-1:0];
      p.mask = mask[0];
      p.red = red[COLOR_BITS-1:0];
      p.green = green[COLOR_BITS-1:0];
      p.blue = blue[COLOR_BITS-1:0];
      return p;
   endfunction

   function automatic int clamp_int(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [BOX_PACK_BITS-1:0] pack_box(input int x, input int y, input int z);
      return {z[BOX_BITS-1:0], y[BOX_BITS-1:0], x[BOX_BITS-1:0]};
   endfunction

   task automatic queue_pixel(input pixel_type p);
      pending_pixels.insert(pending_pixels.size(), p);
      pixels_sent++;
   endtask

   task automatic expect_point(input point_type pt);
      projected_points.insert(projected_points.size(), pt);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CENTER_X:  cfg_centre_col = value[CENTER_BITS-1:0];
         CSR_CENTER_Y:  cfg_centre_row = value[CENTER_BITS-1:0];
         CSR_INV_FOC_X: cfg_recip_fx = value[INV_BITS-1:0];
         CSR_INV_FOC_Y: cfg_recip_fy = value[INV_BITS-1:0];
         CSR_BOX_LOWER: cfg_box_min = value[BOX_PACK_BITS-1:0];
         CSR_BOX_UPPER: cfg_box_max = value[BOX_PACK_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_settings(input logic [CENTER_BITS-1:0] cx,
                                input logic [CENTER_BITS-1:0] cy,
                                input logic [INV_BITS-1:0] fx,
                                input logic [INV_BITS-1:0] fy,
                                input logic [BOX_PACK_BITS-1:0] lo,
                                input logic [BOX_PACK_BITS-1:0] hi);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_INV_FOC_X, fx);
      write_reg(CSR_INV_FOC_Y, fy);
      write_reg(CSR_BOX_LOWER, lo);
      write_reg(CSR_BOX_UPPER, hi);
      settings_used++;
   endtask

   // Returns once every queued pixel has come back as a checked point, so the pipeline
   // is empty and the registers may be rewritten.
   task automatic wait_drained();
      while (points_checked < pixels_sent)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : driver
      logic load;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expect_point(project_pixel(shown_pixel));
         if (!req_valid || !req_stall) begin
            load = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pixels.size() > 0) begin
               shown_pixel = pending_pixels.pop_front();
               load = 1'b1;
               req_col <= shown_pixel.col;
               req_row <= shown_pixel.row;
               req_depth_mm <= shown_pixel.depth;
               req_mask_bit <= shown_pixel.mask;
               req_red_in <= shown_pixel.red;
               req_green_in <= shown_pixel.green;
               req_blue_in <= shown_pixel.blue;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 7) == 0) begin
                  // An occasional long run with no gaps at all.
                  burst_left = 200;
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
            req_valid <= load;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 4));
            stall_left = $urandom_range(8, 80);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_left % 5) < 2);
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (projected_points.size() == 0) begin
            $display("%0t: result transfer with none expected, got x %0d y %0d z %0d",
                     $time, rsp_pos_x, rsp_pos_y, rsp_pos_z);
            error_count++;
         end else begin
            want = projected_points.pop_front();
            check_field("pos_x", $signed(want.x), rsp_pos_x);
            check_field("pos_y", $signed(want.y), rsp_pos_y);
            check_field("pos_z", want.z, rsp_pos_z);
            check_field("red_out", want.red, rsp_red_out);
            check_field("green_out", want.green, rsp_green_out);
            check_field("blue_out", want.blue, rsp_blue_out);
            check_field("point_valid", want.valid, rsp_point_valid);
            check_field("in_filtered", want.kept, rsp_in_filtered);
            points_checked++;
            if (want.kept) points_kept++;
            if (!want.valid) points_empty++;
            if ($signed(want.x) == POS_MIN || $signed(want.x) == POS_MAX ||
                $signed(want.y) == POS_MIN || $signed(want.y) == POS_MAX)
               points_saturated++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d pixels queued, %0d points outstanding",
                  $time, idle_cycles, pending_pixels.size(), projected_points.size());
         $display("tb_depth_pixel_backprojection_core NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      pixel_type focus;
      point_type pt;
      logic [CENTER_BITS-1:0] cx;
      logic [CENTER_BITS-1:0] cy;
      logic [INV_BITS-1:0] fx;
      logic [INV_BITS-1:0] fy;
      logic [BOX_PACK_BITS-1:0] lo;
      logic [BOX_PACK_BITS-1:0] hi;
      logic [63:0] noise;
      int px;
      int py;
      int pz;
      int mx;
      int my;
      int mz;
      int c;
      int r;
      int d;
      int sel;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Default camera and an empty box: corners, the principal point and no reading.
      queue_pixel(pixel_of(0, 0, 1, 1, 0, 0, 0));
      queue_pixel(pixel_of(PIX_MAX, PIX_MAX, DEPTH_MAX, 0, 255, 255, 255));
      queue_pixel(pixel_of(320, 240, 1000, 1, 'h5a, 'ha5, 'h3c));
      queue_pixel(pixel_of(PIX_MAX, 0, 0, 1, 255, 0, 255));
      queue_pixel(pixel_of(0, PIX_MAX, DEPTH_MAX, 1, 0, 255, 0));
      queue_pixel(pixel_of(2048, 2048, 32768, 1, 128, 64, 32));
      wait_drained();

      // Principal point at both ends of its range, largest reciprocal, box spanning all.
      load_settings('0, '1, '1, '1, pack_box(BOX_MIN, BOX_MIN, BOX_MIN),
                    pack_box(BOX_MAX, BOX_MAX, BOX_MAX));
      queue_pixel(pixel_of(PIX_MAX, 0, DEPTH_MAX, 1, 1, 2, 3));
      queue_pixel(pixel_of(0, PIX_MAX, DEPTH_MAX, 1, 4, 5, 6));
      queue_pixel(pixel_of(PIX_MAX, PIX_MAX, 1, 0, 7, 8, 9));
      queue_pixel(pixel_of(0, 0, 0, 1, 255, 255, 255));
      wait_drained();

      // A zero reciprocal focal length flattens x and y to zero.
      load_settings(CENTER_X_RESET, CENTER_Y_RESET, '0, '0, pack_box(BOX_MIN, BOX_MIN, BOX_MIN),
                    pack_box(BOX_MAX, BOX_MAX, BOX_MAX));
      queue_pixel(pixel_of(0, PIX_MAX, 777, 1, 10, 20, 30));
      queue_pixel(pixel_of(PIX_MAX, 0, DEPTH_MAX, 1, 40, 50, 60));
      queue_pixel(pixel_of(1234, 2345, 1, 0, 70, 80, 90));
      wait_drained();

      // Box shrunk to a single point: the bounds are inclusive.
      load_settings(CENTER_X_RESET, CENTER_Y_RESET, INV_FOCAL_RESET, INV_FOCAL_RESET,
                    BOX_RESET, BOX_RESET);
      focus = pixel_of(100, 400, 2500, 1, 11, 22, 33);
      pt = project_pixel(focus);
      write_reg(CSR_BOX_LOWER, pack_box($signed(pt.x), $signed(pt.y), pt.z));
      write_reg(CSR_BOX_UPPER, pack_box($signed(pt.x), $signed(pt.y), pt.z));
      queue_pixel(focus);
      queue_pixel(pixel_of(100, 400, 2500, 0, 11, 22, 33));
      queue_pixel(pixel_of(100, 400, 2501, 1, 11, 22, 33));
      queue_pixel(pixel_of(101, 400, 2500, 1, 11, 22, 33));
      wait_drained();

      // Lower corner above the upper one on x: nothing can be inside.
      write_reg(CSR_BOX_LOWER, pack_box($signed(pt.x) + 1, $signed(pt.y), pt.z));
      queue_pixel(focus);
      wait_drained();

      // Writes to unused register indexes must leave every setting alone.
      write_reg(CSR_SPARE_A, '1);
      write_reg(CSR_SPARE_B, '0);
      queue_pixel(focus);
      queue_pixel(pixel_of(100, 400, 2500, 1, 99, 88, 77));
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         cx = $urandom_range(0, 65535);
         cy = $urandom_range(0, 65535);
         sel = $urandom_range(0, 11);
         fx = (sel == 0) ? '0 : ((sel <= 2) ? $urandom : $urandom_range(1431655, 21474836));
         sel = $urandom_range(0, 11);
         fy = (sel == 0) ? '0 : ((sel <= 2) ? $urandom : $urandom_range(1431655, 21474836));

         // Most boxes are placed around the point of a chosen pixel so that the
         // kept flag is exercised on both sides of each bound.
         c = clamp_int(int'(cx >> CENTER_FRAC) + int'($urandom_range(0, 400)) - 200, 0, PIX_MAX);
         r = clamp_int(int'(cy >> CENTER_FRAC) + int'($urandom_range(0, 400)) - 200, 0, PIX_MAX);
         d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DEPTH_MAX) : $urandom_range(200, 8000);
         focus = pixel_of(c, r, d, 1, 0, 0, 0);
         px = $signed(project_axis(focus.col, cx, fx, focus.depth));
         py = $signed(project_axis(focus.row, cy, fy, focus.depth));
         pz = d;
         mx = $urandom_range(0, 1 << $urandom_range(1, 12));
         my = $urandom_range(0, 1 << $urandom_range(1, 12));
         mz = $urandom_range(0, 1 << $urandom_range(1, 10));
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            lo = pack_box(BOX_MIN, BOX_MIN, BOX_MIN);
            hi = pack_box(BOX_MAX, BOX_MAX, BOX_MAX);
         end else if (sel == 1) begin
            lo = pack_box(clamp_int(px + mx + 1, BOX_MIN, BOX_MAX),
                          clamp_int(py + my + 1, BOX_MIN, BOX_MAX),
                          clamp_int(pz + mz + 1, BOX_MIN, BOX_MAX));
            hi = pack_box(clamp_int(px - mx - 1, BOX_MIN, BOX_MAX),
                          clamp_int(py - my - 1, BOX_MIN, BOX_MAX),
                          clamp_int(pz - mz - 1, BOX_MIN, BOX_MAX));
         end else begin
            lo = pack_box(clamp_int(px - mx, BOX_MIN, BOX_MAX),
                          clamp_int(py - my, BOX_MIN, BOX_MAX),
                          clamp_int(pz - mz, BOX_MIN, BOX_MAX));
            hi = pack_box(clamp_int(px + mx, BOX_MIN, BOX_MAX),
                          clamp_int(py + my, BOX_MIN, BOX_MAX),
                          clamp_int(pz + mz, BOX_MIN, BOX_MAX));
         end
         load_settings(cx, cy, fx, fy, lo, hi);
         if ($urandom_range(0, 3) == 0) begin
            noise = {$urandom, $urandom};
            write_reg(($urandom_range(0, 1) == 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      noise[CSR_DATA_BITS-1:0]);
         end

         for (int i = 0; i < PHASE_PIXELS; i++) begin
            if ($urandom_range(0, 9) < 6) begin
               c = clamp_int(int'(focus.col) + int'($urandom_range(0, 64)) - 32, 0, PIX_MAX);
               r = clamp_int(int'(focus.row) + int'($urandom_range(0, 64)) - 32, 0, PIX_MAX);
               d = clamp_int(int'(focus.depth) + int'($urandom_range(0, 512)) - 256, 1,
                             DEPTH_MAX);
            end else begin
               c = $urandom_range(0, PIX_MAX);
               r = $urandom_range(0, PIX_MAX);
               d = $urandom_range(0, DEPTH_MAX);
            end
            if ($urandom_range(0, 9) == 0) d = 0;
            queue_pixel(pixel_of(c, r, d, ($urandom_range(0, 3) != 0),
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255)));
         end
         wait_drained();
      end

      $display("Checked %0d back-projected pixels over %0d register settings:", points_checked,
               settings_used);
      $display("  %0d kept in the box, %0d without depth, %0d saturated on x or y.",
               points_kept, points_empty, points_saturated);
      if (error_count == 0 && projected_points.size() == 0) begin
         $display("tb_depth_pixel_backprojection_core OK");
      end else begin
         $display("tb_depth_pixel_backprojection_core NOT OK");
      end
      $finish;
   end

endmodule

// ----- depth_pixel_backprojection_core.f -----
+incdir+rtl/core
rtl/core/dpbp_pkg.sv
rtl/core/dpbp_pipe_ctrl.sv
rtl/core/dpbp_project.sv
rtl/core/dpbp_box_check.sv
rtl/core/depth_pixel_backprojection_core.sv
tb/tb_depth_pixel_backprojection_core.sv
